// ----- hdl/mfpm_pkg.sv -----
// ----------------------------------------------------------------------------
// Masked framebuffer pixel mapper package
// Types, action codes, sizing constants and the word merge and colour mapping
// functions that the video memory and the top level share.
// ----------------------------------------------------------------------------
`default_nettype none

package mfpm_pkg;

	// Video memory geometry. RAM_WORDS is a power of two, so reducing an
	// address modulo the depth is a truncation to ADDR_W bits.
	localparam int RAM_WORDS   = 262144;
	localparam int ROW_PITCH   = 512;
	localparam int PAGE_OFFSET = 131072;
	localparam int ADDR_W      = $clog2(RAM_WORDS);

	localparam int ACTION_W = 3;
	localparam int WORD_W   = 16;
	localparam int COLOUR_W = 12;

	localparam logic [ACTION_W-1:0] ACT_RAM_READ   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_RAM_WRITE  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_CTRL_WRITE = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_CTRL_READ  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_MASK_WRITE = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_PIXEL      = 3'd5;

	localparam logic [WORD_W-1:0] CTRL_READ_VALUE = 16'h0060;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [17:0]         word_address;
		logic [WORD_W-1:0]   write_data;
		logic [WORD_W-1:0]   access_mask;
		logic [8:0]          pixel_column;
		logic [7:0]          pixel_row;
	} command_t;

	typedef struct packed {
		logic [WORD_W-1:0]   read_data;
		logic [COLOUR_W-1:0] colour_index;
	} response_t;

	// Port requests towards the video memory.
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [WORD_W-1:0] wr_data;
	} vram_req_t;

	function automatic logic [WORD_W-1:0] merge_bits(
		input logic [WORD_W-1:0] old_word,
		input logic [WORD_W-1:0] data,
		input logic [WORD_W-1:0] mask
	);
		return (old_word & ~mask) | (data & mask);
	endfunction

	// Image B (bit 15) sets the top index bit and takes its low nibble from
	// bits 12..9, blanked when bit 13 is set; image A takes bits 3..0.
	function automatic logic [COLOUR_W-1:0] map_colour(input logic [WORD_W-1:0] w);
		logic [COLOUR_W-1:0] c;
		c = '0;
		c[10:8] = w[8:6];
		if (w[15]) begin
			c[11] = 1'b1;
			c[3:0] = w[13] ? 4'h0 : w[12:9];
		end else begin
			c[3:0] = w[3:0];
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/mfpm_vram.sv -----
// ----------------------------------------------------------------------------
// Video memory
// Single-clock memory of 16-bit words with one write port and one read port;
// the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mfpm_vram (
	input  wire                           clk,
	input  wire mfpm_pkg::vram_req_t      req,
	output logic [mfpm_pkg::WORD_W-1:0]   rd_data
);

	logic [mfpm_pkg::WORD_W-1:0] mem [mfpm_pkg::RAM_WORDS];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/masked_framebuffer_pixel_mapper_unit.sv -----
// ----------------------------------------------------------------------------
// Masked framebuffer pixel mapper
// Two-page bitmap framebuffer of 16-bit words with masked bus writes,
// control and write-protect registers, and pixel fetch with colour mapping.
// ----------------------------------------------------------------------------
//
//  Channel    Ports                   Transaction completes
//  ---------  ----------------------  ------------------------------------
//  command    start, busy, command    rising edge with start high, busy low
//  response   done, response          rising edge ending the cycle done is high
//
// The accepting edge launches the read of the video memory; the following
// edge merges and writes the word back, updates the registers and registers
// the response, so done is high in the cycle after busy. The read-modify-write
// loop waits on the registered read of the memory port. A new command may be
// accepted in the cycle in which done is high. Reset clears the control and
// write-protect registers and the sequencer; the video memory is not cleared.
// The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_framebuffer_pixel_mapper_unit (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	output logic                     busy,
	input  wire mfpm_pkg::command_t  command,
	output logic                     done,
	output mfpm_pkg::response_t      response
);

	// Sequencer codes.
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;

	// The command in flight, and the memory address it read.
	mfpm_pkg::command_t              cmd_q;
	logic [mfpm_pkg::ADDR_W-1:0]     addr_q;

	// Control word and write-protect mask.
	logic [mfpm_pkg::WORD_W-1:0]     ctrl_q;
	logic [mfpm_pkg::WORD_W-1:0]     wpm_q;

	logic                            done_q;
	mfpm_pkg::response_t             resp_q;
	mfpm_pkg::response_t             resp_next;

	mfpm_pkg::vram_req_t             vram_req;
	logic [mfpm_pkg::WORD_W-1:0]     vram_rd_data;
	logic [mfpm_pkg::ADDR_W-1:0]     pix_addr;
	logic [mfpm_pkg::ADDR_W-1:0]     cmd_addr;
	logic                            accept;

	assign busy   = (state_q == ST_EXEC);
	assign accept = start && !busy;

	// Pixel address. Every term is taken modulo the memory depth, which is
	// the same as wrapping the full sum; a column at its top value simply
	// reaches into the next row.
	always_comb begin
		pix_addr = mfpm_pkg::ADDR_W'(command.pixel_row) *
		           mfpm_pkg::ADDR_W'(mfpm_pkg::ROW_PITCH);
		pix_addr = pix_addr + mfpm_pkg::ADDR_W'(command.pixel_column) +
		           mfpm_pkg::ADDR_W'(1);
		if (ctrl_q[0]) begin
			pix_addr = pix_addr + mfpm_pkg::ADDR_W'(mfpm_pkg::PAGE_OFFSET);
		end
	end

	assign cmd_addr = (command.action == mfpm_pkg::ACT_PIXEL) ? pix_addr :
	                  command.word_address[mfpm_pkg::ADDR_W-1:0];

	// The read is launched on acceptance; the write-back happens in the
	// execute cycle. Acceptance is blocked while busy, so a read never
	// overlaps the write-back of the previous transaction.
	always_comb begin
		vram_req.rd_en   = accept;
		vram_req.rd_addr = cmd_addr;
		vram_req.wr_en   = busy && (cmd_q.action == mfpm_pkg::ACT_RAM_WRITE);
		vram_req.wr_addr = addr_q;
		vram_req.wr_data = mfpm_pkg::merge_bits(vram_rd_data, cmd_q.write_data,
		                                        cmd_q.access_mask & wpm_q);
	end

	mfpm_vram u_vram (
		.clk     (clk),
		.req     (vram_req),
		.rd_data (vram_rd_data)
	);

	// Response for the command in flight; actions that return nothing, and
	// the unused codes, give zero in both fields.
	always_comb begin
		resp_next = '0;
		unique case (cmd_q.action)
			mfpm_pkg::ACT_RAM_READ: begin
				resp_next.read_data = vram_rd_data;
			end
			mfpm_pkg::ACT_CTRL_READ: begin
				resp_next.read_data = mfpm_pkg::CTRL_READ_VALUE;
			end
			mfpm_pkg::ACT_PIXEL: begin
				resp_next.colour_index = mfpm_pkg::map_colour(vram_rd_data);
			end
			default: begin
				resp_next = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			ctrl_q  <= '0;
			wpm_q   <= '0;
		end else begin
			done_q <= busy;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					if (cmd_q.action == mfpm_pkg::ACT_CTRL_WRITE) begin
						ctrl_q <= mfpm_pkg::merge_bits(ctrl_q, cmd_q.write_data,
						                               cmd_q.access_mask);
					end
					if (cmd_q.action == mfpm_pkg::ACT_MASK_WRITE) begin
						wpm_q <= mfpm_pkg::merge_bits(wpm_q, cmd_q.write_data,
						                              cmd_q.access_mask);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= command;
			addr_q <= cmd_addr;
		end
		if (busy) begin
			resp_q <= resp_next;
		end
	end

	assign done     = done_q;
	assign response = resp_q;

	// A response follows an execute cycle.
	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_EXEC))
		else $error("response strobe without an execute cycle");

	// An accepted command occupies the block in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted command did not enter execution");

	// Execution never continues into the following cycle.
	a_exec_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("execute state held for more than one cycle");

	// Only a pixel fetch may deliver a colour index.
	a_colour_only_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(cmd_q.action != mfpm_pkg::ACT_PIXEL)) |->
		(response.colour_index == '0))
		else $error("colour index on a non-pixel transaction");

endmodule

`default_nettype wire
